// ===== rtl/scrd_pkg.sv =====
package scrd_pkg;

  localparam int unsigned ANGLE_ITERATIONS_DEF = 16;
  localparam int unsigned MAX_RESOLUTION_DEF   = 4096;

  localparam int unsigned CX_W = 34;
  localparam int unsigned CZ_W = 26;
  localparam int unsigned ANG_W = 25;
  localparam int unsigned SC_W = 20;
  localparam int unsigned OUT_W = 19;
  localparam int unsigned NUM_W = 58;

  localparam logic [ANG_W-1:0] DEG360 = 25'd23592960;
  localparam logic [ANG_W-1:0] DEG180 = 25'd11796480;
  localparam logic signed [ANG_W-1:0] SDEG180 = 25'sd11796480;
  localparam logic signed [ANG_W-1:0] SDEG90  = 25'sd5898240;
  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] CFG_HRES  = 3'd0;
  localparam logic [2:0] CFG_VRES  = 3'd1;
  localparam logic [2:0] CFG_PIX   = 3'd2;
  localparam logic [2:0] CFG_AZMAX = 3'd3;
  localparam logic [2:0] CFG_ELMAX = 3'd4;
  localparam logic [2:0] CFG_RIGHT = 3'd5;
  localparam logic [2:0] CFG_UP    = 3'd6;
  localparam logic [2:0] CFG_BACK  = 3'd7;

  typedef struct packed {
    logic                   vld;
    logic                   flip;
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } rot_t;

  function automatic logic signed [CZ_W-1:0] atan_deg(input int unsigned idx);
    logic signed [CZ_W-1:0] v;
    case (idx)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/scrd_div_cell.sv =====
module scrd_div_cell #(
  parameter int unsigned D_W = 37
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic                           neg_i,
  input  logic [D_W-1:0]                 dv_i,
  input  logic [D_W-1:0]                 rem_i,
  input  logic [scrd_pkg::NUM_W-1:0]     num_i,
  input  logic [scrd_pkg::ANG_W-1:0]     m_i,
  output logic                           vld_o,
  output logic                           neg_o,
  output logic [D_W-1:0]                 dv_o,
  output logic [D_W-1:0]                 rem_o,
  output logic [scrd_pkg::NUM_W-1:0]     num_o,
  output logic [scrd_pkg::ANG_W-1:0]     m_o
);

  logic [D_W:0]                 r2;
  logic [D_W:0]                 rs;
  logic                         ge;
  logic [scrd_pkg::ANG_W:0]     m2;
  logic [D_W-1:0]               rem_d;
  logic [scrd_pkg::ANG_W-1:0]   m_d;

  always_comb begin
    r2    = {rem_i, num_i[scrd_pkg::NUM_W-1]};
    ge    = r2 >= {1'b0, dv_i};
    rs    = ge ? (r2 - {1'b0, dv_i}) : r2;
    rem_d = rs[D_W-1:0];
    m2    = {m_i, ge};
    if (m2 >= {1'b0, scrd_pkg::DEG360}) begin
      m2 = m2 - {1'b0, scrd_pkg::DEG360};
    end
    m_d = m2[scrd_pkg::ANG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_o <= neg_i;
      dv_o  <= dv_i;
      rem_o <= rem_d;
      num_o <= {num_i[scrd_pkg::NUM_W-2:0], 1'b0};
      m_o   <= m_d;
    end
  end

endmodule

// ===== rtl/scrd_cordic_cell.sv =====
module scrd_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  scrd_pkg::rot_t  rot_i,
  output scrd_pkg::rot_t  rot_o
);

  scrd_pkg::rot_t                   rot_d;
  logic signed [scrd_pkg::CZ_W-1:0] atn;

  always_comb begin
    atn   = scrd_pkg::atan_deg(IDX);
    rot_d = rot_i;
    if (rot_i.z >= 0) begin
      rot_d.x = rot_i.x - (rot_i.y >>> IDX);
      rot_d.y = rot_i.y + (rot_i.x >>> IDX);
      rot_d.z = rot_i.z - atn;
    end else begin
      rot_d.x = rot_i.x + (rot_i.y >>> IDX);
      rot_d.y = rot_i.y - (rot_i.x >>> IDX);
      rot_d.z = rot_i.z + atn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_o <= '0;
    end else if (en_i) begin
      rot_o <= rot_d;
    end
  end

endmodule

// ===== rtl/scrd_combine.sv =====
module scrd_combine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  scrd_pkg::rot_t                     lam_i,
  input  scrd_pkg::rot_t                     psi_i,
  input  logic [47:0]                        basis_u_i,
  input  logic [47:0]                        basis_v_i,
  input  logic [47:0]                        basis_w_i,
  output logic                               vld_o,
  output logic signed [scrd_pkg::OUT_W-1:0]  dir_x_o,
  output logic signed [scrd_pkg::OUT_W-1:0]  dir_y_o,
  output logic signed [scrd_pkg::OUT_W-1:0]  dir_z_o
);

  localparam int unsigned SC_W = scrd_pkg::SC_W;
  localparam int unsigned CX_W = scrd_pkg::CX_W;
  localparam logic signed [CX_W-1:0] RND14 = 34'sd8192;
  localparam logic signed [39:0]     RND16 = 40'sd32768;
  localparam logic signed [37:0]     RNDS  = 38'sd8192;
  localparam logic signed [23:0]     OMAX  = 24'sd262143;
  localparam logic signed [23:0]     OMIN  = -24'sd262144;

  logic                   v0_q, v1_q, v2_q;
  logic signed [SC_W-1:0] sl_q, cl_q, sp_q, cp_q;
  logic signed [39:0]     pa_q, pc_q;
  logic signed [SC_W-1:0] sp1_q;
  logic signed [35:0]     pr_q [3];

  logic signed [CX_W-1:0] lx, ly, px, py;
  logic signed [CX_W-1:0] lxr, lyr, pxr, pyr;
  logic signed [SC_W-1:0] sl_d, cl_d, sp_d, cp_d;

  always_comb begin
    lx  = lam_i.flip ? -lam_i.x : lam_i.x;
    ly  = lam_i.flip ? -lam_i.y : lam_i.y;
    px  = psi_i.flip ? -psi_i.x : psi_i.x;
    py  = psi_i.flip ? -psi_i.y : psi_i.y;
    lxr = lx + RND14;
    lyr = ly + RND14;
    pxr = px + RND14;
    pyr = py + RND14;
    sl_d = lyr[CX_W-1:14];
    cl_d = lxr[CX_W-1:14];
    sp_d = pyr[CX_W-1:14];
    cp_d = pxr[CX_W-1:14];
  end

  logic signed [39:0]     ra, rc;
  logic signed [SC_W-1:0] ta, tb, tc;
  logic signed [15:0]     bu [3];
  logic signed [15:0]     bv [3];
  logic signed [15:0]     bw [3];
  logic signed [35:0]     pu [3];
  logic signed [35:0]     pv [3];
  logic signed [35:0]     pw [3];

  always_comb begin
    ra = pa_q + RND16;
    rc = pc_q + RND16;
    ta = ra[35:16];
    tc = -rc[35:16];
    tb = sp1_q;
    for (int j = 0; j < 3; j++) begin
      bu[j] = basis_u_i[16*j +: 16];
      bv[j] = basis_v_i[16*j +: 16];
      bw[j] = basis_w_i[16*j +: 16];
      pu[j] = 36'(ta) * 36'(bu[j]);
      pv[j] = 36'(tb) * 36'(bv[j]);
      pw[j] = 36'(tc) * 36'(bw[j]);
    end
  end

  logic signed [35:0] pu_q [3];
  logic signed [35:0] pv_q [3];
  logic signed [35:0] pw_q [3];
  logic signed [37:0] sm   [3];
  logic signed [23:0] sh   [3];
  logic signed [scrd_pkg::OUT_W-1:0] sat [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sm[j] = 38'(pu_q[j]) + 38'(pv_q[j]) + 38'(pw_q[j]) + RNDS;
      sh[j] = sm[j][37:14];
      if (sh[j] > OMAX) begin
        sat[j] = OMAX[scrd_pkg::OUT_W-1:0];
      end else if (sh[j] < OMIN) begin
        sat[j] = OMIN[scrd_pkg::OUT_W-1:0];
      end else begin
        sat[j] = sh[j][scrd_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      vld_o <= 1'b0;
    end else if (en_i) begin
      v0_q  <= lam_i.vld & psi_i.vld;
      v1_q  <= v0_q;
      v2_q  <= v1_q;
      vld_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sl_q  <= sl_d;
      cl_q  <= cl_d;
      sp_q  <= sp_d;
      cp_q  <= cp_d;
      pa_q  <= 40'(cp_q) * 40'(sl_q);
      pc_q  <= 40'(cp_q) * 40'(cl_q);
      sp1_q <= sp_q;
      for (int j = 0; j < 3; j++) begin
        pu_q[j] <= pu[j];
        pv_q[j] <= pv[j];
        pw_q[j] <= pw[j];
      end
      dir_x_o <= sat[0];
      dir_y_o <= sat[1];
      dir_z_o <= sat[2];
    end
  end

endmodule

// ===== rtl/spherical_camera_ray_direction.sv =====
// Throughput: one request per cycle; a row of 58 divider cells per angle yields
// one quotient bit each, followed by one CORDIC cell per iteration.
// The whole pipeline holds while the output register is full and not taken.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the default
// camera registers.
module spherical_camera_ray_direction #(
  parameter int unsigned ANGLE_ITERATIONS = scrd_pkg::ANGLE_ITERATIONS_DEF,
  parameter int unsigned MAX_RESOLUTION   = scrd_pkg::MAX_RESOLUTION_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // plane_x[31:0], plane_y[63:32]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // dir_x[18:0], dir_y[37:19], dir_z[56:38], zero
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  localparam int unsigned RES_W  = $clog2(MAX_RESOLUTION + 1);
  localparam int unsigned CRES_W = (RES_W < 13) ? RES_W : 13;
  localparam int unsigned D_W    = 24 + CRES_W;
  localparam int unsigned NUM_W  = scrd_pkg::NUM_W;
  localparam int unsigned ANG_W  = scrd_pkg::ANG_W;

  logic [12:0] hres_q, vres_q;
  logic [23:0] pix_q, azmax_q;
  logic [22:0] elmax_q;
  logic [47:0] right_q, up_q, back_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hres_q  <= 13'd640;
      vres_q  <= 13'd480;
      pix_q   <= 24'd65536;
      azmax_q <= 24'd11796480;
      elmax_q <= 23'd5898240;
      right_q <= 48'd16384;
      up_q    <= 48'd1073741824;
      back_q  <= 48'd70368744177664;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        scrd_pkg::CFG_HRES:  hres_q  <= cfg_data_i[12:0];
        scrd_pkg::CFG_VRES:  vres_q  <= cfg_data_i[12:0];
        scrd_pkg::CFG_PIX:   pix_q   <= cfg_data_i[23:0];
        scrd_pkg::CFG_AZMAX: azmax_q <= cfg_data_i[23:0];
        scrd_pkg::CFG_ELMAX: elmax_q <= cfg_data_i[22:0];
        scrd_pkg::CFG_RIGHT: right_q <= cfg_data_i;
        scrd_pkg::CFG_UP:    up_q    <= cfg_data_i;
        scrd_pkg::CFG_BACK:  back_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld;
  assign en              = !out_vld || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vld;

  logic [23:0]       s_eff;
  logic [CRES_W-1:0] hres_eff, vres_eff;
  logic [31:0]       px_raw, py_raw, px_mag, py_mag;

  always_comb begin
    s_eff = (pix_q == 24'd0) ? 24'd1 : pix_q;
    if (hres_q == 13'd0) begin
      hres_eff = CRES_W'(1);
    end else if ({19'd0, hres_q} > 32'(MAX_RESOLUTION)) begin
      hres_eff = CRES_W'(MAX_RESOLUTION);
    end else begin
      hres_eff = CRES_W'(hres_q);
    end
    if (vres_q == 13'd0) begin
      vres_eff = CRES_W'(1);
    end else if ({19'd0, vres_q} > 32'(MAX_RESOLUTION)) begin
      vres_eff = CRES_W'(MAX_RESOLUTION);
    end else begin
      vres_eff = CRES_W'(vres_q);
    end
    px_raw = s_axis_tdata_i[31:0];
    py_raw = s_axis_tdata_i[63:32];
    px_mag = px_raw[31] ? (~px_raw + 32'd1) : px_raw;
    py_mag = py_raw[31] ? (~py_raw + 32'd1) : py_raw;
  end

  logic           v0_q;
  logic           nl_q, np_q;
  logic [55:0]    prl_q, prp_q;
  logic [D_W-1:0] dl_q, dp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nl_q  <= px_raw[31];
      np_q  <= py_raw[31];
      prl_q <= 56'(px_mag) * 56'(azmax_q);
      prp_q <= 56'(py_mag) * 56'(elmax_q);
      dl_q  <= D_W'(s_eff) * D_W'(hres_eff);
      dp_q  <= D_W'(s_eff) * D_W'(vres_eff);
    end
  end

  logic             lv  [0:NUM_W];
  logic             ln  [0:NUM_W];
  logic [D_W-1:0]   ld  [0:NUM_W];
  logic [D_W-1:0]   lr  [0:NUM_W];
  logic [NUM_W-1:0] lnm [0:NUM_W];
  logic [ANG_W-1:0] lm  [0:NUM_W];
  logic             pv  [0:NUM_W];
  logic             pn  [0:NUM_W];
  logic [D_W-1:0]   pd  [0:NUM_W];
  logic [D_W-1:0]   pr  [0:NUM_W];
  logic [NUM_W-1:0] pnm [0:NUM_W];
  logic [ANG_W-1:0] pm  [0:NUM_W];

  assign lv[0]  = v0_q;
  assign ln[0]  = nl_q;
  assign ld[0]  = dl_q;
  assign lr[0]  = '0;
  assign lnm[0] = {1'b0, prl_q, 1'b0} + NUM_W'(dl_q >> 1);
  assign lm[0]  = '0;
  assign pv[0]  = v0_q;
  assign pn[0]  = np_q;
  assign pd[0]  = dp_q;
  assign pr[0]  = '0;
  assign pnm[0] = {1'b0, prp_q, 1'b0} + NUM_W'(dp_q >> 1);
  assign pm[0]  = '0;

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    scrd_div_cell #(.D_W(D_W)) u_lam (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(lv[k]), .neg_i(ln[k]), .dv_i(ld[k]), .rem_i(lr[k]), .num_i(lnm[k]),
      .m_i(lm[k]),
      .vld_o(lv[k+1]), .neg_o(ln[k+1]), .dv_o(ld[k+1]), .rem_o(lr[k+1]),
      .num_o(lnm[k+1]), .m_o(lm[k+1])
    );
    scrd_div_cell #(.D_W(D_W)) u_psi (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(pv[k]), .neg_i(pn[k]), .dv_i(pd[k]), .rem_i(pr[k]), .num_i(pnm[k]),
      .m_i(pm[k]),
      .vld_o(pv[k+1]), .neg_o(pn[k+1]), .dv_o(pd[k+1]), .rem_o(pr[k+1]),
      .num_o(pnm[k+1]), .m_o(pm[k+1])
    );
  end

  function automatic scrd_pkg::rot_t fold(input logic vld, input logic neg,
                                          input logic [ANG_W-1:0] m);
    scrd_pkg::rot_t          o;
    logic [ANG_W-1:0]        r;
    logic signed [ANG_W-1:0] a;
    r = (neg && (m != '0)) ? (scrd_pkg::DEG360 - m) : m;
    a = (r >= scrd_pkg::DEG180) ? signed'(r - scrd_pkg::DEG360) : signed'(r);
    o.vld  = vld;
    o.x    = scrd_pkg::CORDIC_GAIN;
    o.y    = '0;
    o.flip = 1'b0;
    if (a > scrd_pkg::SDEG90) begin
      o.z    = scrd_pkg::CZ_W'(a - scrd_pkg::SDEG180);
      o.flip = 1'b1;
    end else if (a < -scrd_pkg::SDEG90) begin
      o.z    = scrd_pkg::CZ_W'(a + scrd_pkg::SDEG180);
      o.flip = 1'b1;
    end else begin
      o.z = scrd_pkg::CZ_W'(a);
    end
    return o;
  endfunction

  scrd_pkg::rot_t lrot [0:ANGLE_ITERATIONS];
  scrd_pkg::rot_t prot [0:ANGLE_ITERATIONS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lrot[0] <= '0;
      prot[0] <= '0;
    end else if (en) begin
      lrot[0] <= fold(lv[NUM_W], ln[NUM_W], lm[NUM_W]);
      prot[0] <= fold(pv[NUM_W], pn[NUM_W], pm[NUM_W]);
    end
  end

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
    scrd_cordic_cell #(.IDX(i)) u_lam (
      .clk_i, .rst_ni, .en_i(en), .rot_i(lrot[i]), .rot_o(lrot[i+1])
    );
    scrd_cordic_cell #(.IDX(i)) u_psi (
      .clk_i, .rst_ni, .en_i(en), .rot_i(prot[i]), .rot_o(prot[i+1])
    );
  end

  logic signed [scrd_pkg::OUT_W-1:0] dx, dy, dz;

  scrd_combine u_comb (
    .clk_i, .rst_ni, .en_i(en),
    .lam_i(lrot[ANGLE_ITERATIONS]), .psi_i(prot[ANGLE_ITERATIONS]),
    .basis_u_i(right_q), .basis_v_i(up_q), .basis_w_i(back_q),
    .vld_o(out_vld), .dir_x_o(dx), .dir_y_o(dy), .dir_z_o(dz)
  );

  assign m_axis_tdata_o = {7'd0, dz, dy, dx};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;   // plane_x[31:0], plane_y[63:32]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;   // dir_x[18:0], dir_y[37:19], dir_z[56:38], zero
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [47:0] cfg_data_i;

  spherical_camera_ray_direction u_top (.*);

  localparam longint ITERS = 16;
  localparam longint MAXRES = 4096;
  localparam longint D360 = 64'd23592960;
  localparam longint D180 = 64'd11796480;
  localparam longint D90 = 64'd5898240;
  localparam int LATENCY = 80;

  // camera registers as the predictor sees them
  logic [12:0] hres_q, vres_q;
  logic [23:0] pix_q, azmax_q;
  logic [22:0] elmax_q;
  logic [47:0] right_q, up_q, back_q;

  logic [56:0] dir_queue[$];
  int errors = 0;
  int n_req = 0;
  int n_rsp = 0;
  int idle_pct = 16;
  bit sink_hold = 0;

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  initial begin
    #100ms;
    $display("tb: done, errors");
    $finish;
  end

  function automatic longint atan_tab(int i);
    longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                      14668, 7334, 3667, 1833, 917, 458, 229, 115,
                      57, 29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic longint rnd_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint plane_angle(logic [31:0] raw, longint res, longint amax);
    longint p, mag, s, d, q, r;
    p = longint'(signed'(raw));
    mag = (p < 0) ? -p : p;
    s = (pix_q == 0) ? 1 : longint'(pix_q);
    if (res == 0) res = 1;
    if (res > MAXRES) res = MAXRES;
    d = s * res;
    q = (2 * mag * amax + d / 2) / d;
    r = q % D360;
    if (p < 0 && r != 0) r = D360 - r;
    return (r >= D180) ? r - D360 : r;
  endfunction

  function automatic void cordic_sin_cos(input longint a, output longint sn,
                                         output longint cs);
    longint x, y, z, nx;
    bit flip;
    x = 652032874; y = 0; z = a; flip = 0;
    if (a > D90) begin
      z = a - D180; flip = 1;
    end else if (a < -D90) begin
      z = a + D180; flip = 1;
    end
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sn = rnd_shift(y, 14);
    cs = rnd_shift(x, 14);
  endfunction

  function automatic logic [56:0] ray_dir(logic [63:0] pt);
    longint lam, psi, sl, cl, sp, cp, a, b, c, sum, uj, vj, wj;
    logic [56:0] res;
    lam = plane_angle(pt[31:0], hres_q, azmax_q);
    psi = plane_angle(pt[63:32], vres_q, elmax_q);
    cordic_sin_cos(lam, sl, cl);
    cordic_sin_cos(psi, sp, cp);
    a = rnd_shift(cp * sl, 16);
    b = sp;
    c = -rnd_shift(cp * cl, 16);
    for (int j = 0; j < 3; j++) begin
      uj = longint'(signed'(right_q[16*j +: 16]));
      vj = longint'(signed'(up_q[16*j +: 16]));
      wj = longint'(signed'(back_q[16*j +: 16]));
      sum = rnd_shift(a * uj + b * vj + c * wj, 14);
      if (sum > 262143) sum = 262143;
      if (sum < -262144) sum = -262144;
      res[19*j +: 19] = sum[18:0];
    end
    return res;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      scrd_pkg::CFG_HRES:  hres_q = val[12:0];
      scrd_pkg::CFG_VRES:  vres_q = val[12:0];
      scrd_pkg::CFG_PIX:   pix_q = val[23:0];
      scrd_pkg::CFG_AZMAX: azmax_q = val[23:0];
      scrd_pkg::CFG_ELMAX: elmax_q = val[22:0];
      scrd_pkg::CFG_RIGHT: right_q = val;
      scrd_pkg::CFG_UP:    up_q = val;
      scrd_pkg::CFG_BACK:  back_q = val;
      default: ;
    endcase
  endtask

  // send one request; valid stays high across back-to-back requests
  task automatic send_point(input logic [31:0] px, input logic [31:0] py);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {py, px};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    dir_queue.push_back(ray_dir({py, px}));
    n_req++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (dir_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_plane();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      2: return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
      default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic logic [47:0] rand_basis();
    logic [47:0] b;
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(3))
        0: b[16*j +: 16] = 16'h4000;
        1: b[16*j +: 16] = 16'hC000;
        default: b[16*j +: 16] = $urandom();
      endcase
    end
    return b;
  endfunction

  task automatic test_directed_extremes();
    logic [31:0] v[8] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h0014_0000, 32'hFFEC_0000, 32'h0000_8000};
    for (int i = 0; i < 8; i++) send_point(v[i], v[7 - i]);
    send_point(32'h0140_0000, 32'h00F0_0000);
    send_point(32'hFEC0_0000, 32'hFF10_0000);
    send_point(32'h00A0_0000, 32'h0078_0000);
    drain();
  endtask

  task automatic test_special_registers();
    write_reg(scrd_pkg::CFG_HRES, 48'd0);
    write_reg(scrd_pkg::CFG_VRES, 48'd8191);
    write_reg(scrd_pkg::CFG_PIX, 48'd0);
    for (int i = 0; i < 4; i++) send_point($urandom_range(300), $urandom_range(300));
    drain();
    write_reg(scrd_pkg::CFG_HRES, 48'd4097);
    write_reg(scrd_pkg::CFG_VRES, 48'd1);
    write_reg(scrd_pkg::CFG_PIX, 48'hFF_FFFF);
    write_reg(scrd_pkg::CFG_AZMAX, 48'hFF_FFFF);
    write_reg(scrd_pkg::CFG_ELMAX, 48'h7F_FFFF);
    write_reg(scrd_pkg::CFG_RIGHT, 48'h7FFF_7FFF_7FFF);
    write_reg(scrd_pkg::CFG_UP, 48'h7FFF_7FFF_7FFF);
    write_reg(scrd_pkg::CFG_BACK, 48'h8000_8000_8000);
    for (int i = 0; i < 6; i++) send_point($urandom(), $urandom());
    drain();
    write_reg(scrd_pkg::CFG_AZMAX, 48'd0);
    write_reg(scrd_pkg::CFG_ELMAX, 48'd0);
    send_point(32'h1234_5678, 32'h8765_4321);
    send_point(32'hFFFF_FFFF, 32'h0);
    drain();
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_point(rand_plane(), rand_plane());
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(scrd_pkg::CFG_HRES, 48'($urandom_range(4096, 1)));
      write_reg(scrd_pkg::CFG_VRES, 48'($urandom_range(4096, 1)));
      write_reg(scrd_pkg::CFG_PIX, 48'($urandom_range(1 << 20, 1)));
      write_reg(scrd_pkg::CFG_AZMAX, 48'($urandom_range(11796480)));
      write_reg(scrd_pkg::CFG_ELMAX, 48'($urandom_range(5898240)));
      write_reg(scrd_pkg::CFG_RIGHT, rand_basis());
      write_reg(scrd_pkg::CFG_UP, rand_basis());
      write_reg(scrd_pkg::CFG_BACK, rand_basis());
      idle_pct = (phase == 2) ? 0 : 16;
      run_random(240);
      drain();
    end
    idle_pct = 16;
  endtask

  task automatic test_backpressure();
    sink_hold = 1;
    run_random(150);
    sink_hold = 0;
    drain();
  endtask

  // result side: random stalls, plus a long hold when asked
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold) begin
        m_axis_tready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        sink_hold = 0;
      end
      m_axis_tready_i <= (idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk_i) begin
    logic [56:0] exp_dir;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_rsp++;
      if (dir_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        exp_dir = dir_queue.pop_front();
        for (int j = 0; j < 3; j++)
          if (m_axis_tdata_o[19*j +: 19] !== exp_dir[19*j +: 19]) begin
            $display("%0t: dir[%0d] expected %h actual %h", $time, j,
                     exp_dir[19*j +: 19], m_axis_tdata_o[19*j +: 19]);
            errors++;
          end
        if (m_axis_tdata_o[63:57] !== 7'd0) begin
          $display("%0t: pad expected 0 actual %h", $time, m_axis_tdata_o[63:57]);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = scrd_pkg::CFG_HRES;
    cfg_data_i = '0;
    hres_q = 640; vres_q = 480; pix_q = 65536;
    azmax_q = 11796480; elmax_q = 5898240;
    right_q = 48'd16384; up_q = 48'd1073741824; back_q = 48'd70368744177664;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_special_registers();
    test_backpressure();
    test_random_configs();
    $display("tb: %0d requests sent, %0d results checked over 10 camera setups", n_req, n_rsp);
    $display("tb: covered register extremes, full-rate bursts and long output stalls");
    if (errors == 0 && dir_queue.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
